// ===== sv/software_timer_bank_defines.svh =====
// Assertion macros shared by the software timer bank RTL.
`ifndef SOFTWARE_TIMER_BANK_DEFINES_SVH
`define SOFTWARE_TIMER_BANK_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cons follows whenever ante holds, outside reset.
`define STB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cond never holds, outside reset.
`define STB_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define STB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`define STB_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== sv/stb_pkg.sv =====
// Types and constants shared by the software timer bank modules.
package stb_pkg;

  // Operation codes of the request channel
  localparam logic [3:0] OP_TICK        = 4'd0;
  localparam logic [3:0] OP_READ_FREE   = 4'd1;
  localparam logic [3:0] OP_RESET_FREE  = 4'd2;
  localparam logic [3:0] OP_READ_GATED  = 4'd3;
  localparam logic [3:0] OP_START       = 4'd4;
  localparam logic [3:0] OP_STOP        = 4'd5;
  localparam logic [3:0] OP_PAUSE       = 4'd6;
  localparam logic [3:0] OP_CONTINUE    = 4'd7;
  localparam logic [3:0] OP_CLEAR_ALL   = 4'd8;
  // Internal kind for requests that change nothing
  localparam logic [3:0] OP_NOP         = 4'd15;

  // Gated counter states
  localparam logic [1:0] ST_STOPPED = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_PAUSED  = 2'd2;

  // One slot as stored in the bank memory
  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] gated;
    logic [31:0] free;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  // Classified request passed from front to back
  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  slot;
    logic        slot_ok;
    logic [31:0] amount;
  } req_t;

  // Head of the request queue
  typedef struct packed {
    logic valid;
    req_t req;
  } head_t;

  // Status from back to front
  typedef struct packed {
    logic pop;
    logic init_busy;
  } bk_stat_t;

endpackage

// ===== sv/stb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module stb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/stb_front.sv =====
// Request intake: classify each request and hold it in a two-entry queue.
`include "software_timer_bank_defines.svh"

module stb_front #(
  parameter int NUM_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [3:0]        in_operation,
  input  logic [3:0]        in_timer_index,
  input  logic [31:0]       in_tick_amount,
  input  stb_pkg::bk_stat_t stat,
  output stb_pkg::head_t    head
);

  import stb_pkg::*;

  req_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  req_t       cls;

  // Map each request to the kind of work the back end has to do
  always_comb begin
    cls.slot    = in_timer_index;
    cls.amount  = in_tick_amount;
    cls.slot_ok = ({28'd0, in_timer_index} < 32'(NUM_SLOTS));
    case (in_operation)
      OP_TICK:      cls.kind = (in_tick_amount != 32'd0) ? OP_TICK : OP_NOP;
      OP_CLEAR_ALL: cls.kind = OP_CLEAR_ALL;
      OP_READ_FREE, OP_RESET_FREE, OP_READ_GATED, OP_START, OP_STOP,
      OP_PAUSE, OP_CONTINUE: begin
        cls.kind = cls.slot_ok ? in_operation : OP_NOP;
      end
      default:      cls.kind = OP_NOP;
    endcase
  end

  assign in_stall   = (cnt_r == 2'd2) || stat.init_busy;
  assign push       = in_valid && !in_stall;
  assign head.valid = (cnt_r != 2'd0);
  assign head.req   = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (stat.pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !stat.pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (!push && stat.pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  `STB_ASSERT_NEVER(a_pop_empty, clk, rst_n, stat.pop && (cnt_r == 2'd0), "pop from empty queue")
  `STB_ASSERT_NEVER(a_q_over, clk, rst_n, cnt_r == 2'd3, "request queue overflow")

endmodule

// ===== sv/stb_back.sv =====
// Command sequencer: sweeps, per-slot updates, clearing and the result register.
`include "software_timer_bank_defines.svh"

module stb_back #(
  parameter int NUM_SLOTS = 16,
  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
  localparam int CW = $clog2(NUM_SLOTS + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  stb_pkg::head_t              head,
  output stb_pkg::bk_stat_t           stat,
  output logic                        ram_re,
  output logic [AW-1:0]               ram_raddr,
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output logic [stb_pkg::ENTRY_W-1:0] ram_wdata,
  input  logic [stb_pkg::ENTRY_W-1:0] ram_rdata,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [31:0]                 out_count_value,
  output logic [1:0]                  out_slot_state
);

  import stb_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_POST  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  req_t          cur_r, cur_nxt;
  logic          wb_v_r, wb_v_nxt;
  logic [AW-1:0] wb_addr_r, wb_addr_nxt;
  logic          report_r, report_nxt;
  logic [31:0]   res_count_r, res_count_nxt;
  logic [1:0]    res_state_r, res_state_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_count_r, out_count_nxt;
  logic [1:0]    out_state_r, out_state_nxt;
  slot_entry_t   rd_e;
  slot_entry_t   tick_e;
  slot_entry_t   exec_e;
  logic          exec_we;
  logic [31:0]   exec_val;
  logic          sweep_rd;

  function automatic logic [AW-1:0] slot_addr(input logic [3:0] s);
    logic [AW+3:0] w;
    w = {{AW{1'b0}}, s};
    return w[AW-1:0];
  endfunction

  assign rd_e     = slot_entry_t'(ram_rdata);
  assign sweep_rd = (cnt_r < CW'(NUM_SLOTS));

  // Tick update of one slot
  always_comb begin
    tick_e       = rd_e;
    tick_e.free  = rd_e.free + cur_r.amount;
    if (rd_e.st == ST_RUNNING) begin
      tick_e.gated = rd_e.gated + cur_r.amount;
    end
  end

  // Per-slot command update
  always_comb begin
    exec_e   = rd_e;
    exec_we  = 1'b0;
    exec_val = 32'd0;
    case (cur_r.kind)
      OP_READ_FREE:  exec_val = rd_e.free;
      OP_READ_GATED: exec_val = rd_e.gated;
      OP_RESET_FREE: begin
        exec_e.free = 32'd0;
        exec_we     = 1'b1;
      end
      OP_START: begin
        exec_e.gated = 32'd0;
        exec_e.st    = ST_RUNNING;
        exec_we      = 1'b1;
      end
      OP_STOP: begin
        exec_e.gated = 32'd0;
        exec_e.st    = ST_STOPPED;
        exec_we      = 1'b1;
      end
      OP_PAUSE: begin
        if (rd_e.st == ST_RUNNING) begin
          exec_e.st = ST_PAUSED;
          exec_we   = 1'b1;
        end
      end
      OP_CONTINUE: begin
        if (rd_e.st == ST_PAUSED) begin
          exec_e.st = ST_RUNNING;
          exec_we   = 1'b1;
        end
      end
      default: exec_we = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cur_nxt        = cur_r;
    wb_v_nxt       = 1'b0;
    wb_addr_nxt    = wb_addr_r;
    report_nxt     = report_r;
    res_count_nxt  = res_count_r;
    res_state_nxt  = res_state_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_count_nxt  = out_count_r;
    out_state_nxt  = out_state_r;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    stat.pop       = 1'b0;
    stat.init_busy = (state_r == S_CLEAR) && !report_r;
    case (state_r)
      S_CLEAR: begin
        if (sweep_rd) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_r[AW-1:0];
          cnt_nxt   = cnt_r + CW'(1);
        end else begin
          state_nxt  = report_r ? S_POST : S_IDLE;
          report_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (head.valid) begin
          stat.pop      = 1'b1;
          cur_nxt       = head.req;
          cnt_nxt       = '0;
          res_count_nxt = 32'd0;
          res_state_nxt = ST_STOPPED;
          case (head.req.kind)
            OP_CLEAR_ALL: begin
              report_nxt = 1'b1;
              state_nxt  = S_CLEAR;
            end
            OP_TICK: state_nxt = S_SWEEP;
            default: begin
              if (head.req.slot_ok) begin
                ram_re    = 1'b1;
                ram_raddr = slot_addr(head.req.slot);
                state_nxt = S_EXEC;
              end else begin
                state_nxt = S_POST;
              end
            end
          endcase
        end
      end
      S_SWEEP: begin
        if (sweep_rd) begin
          ram_re      = 1'b1;
          ram_raddr   = cnt_r[AW-1:0];
          wb_v_nxt    = 1'b1;
          wb_addr_nxt = cnt_r[AW-1:0];
          cnt_nxt     = cnt_r + CW'(1);
        end
        if (wb_v_r) begin
          ram_we    = 1'b1;
          ram_waddr = wb_addr_r;
          ram_wdata = tick_e;
          if (cur_r.slot_ok && (wb_addr_r == slot_addr(cur_r.slot))) begin
            res_state_nxt = rd_e.st;
          end
        end
        if (!sweep_rd && !wb_v_r) begin
          state_nxt = S_POST;
        end
      end
      S_EXEC: begin
        ram_we        = exec_we;
        ram_waddr     = slot_addr(cur_r.slot);
        ram_wdata     = exec_e;
        res_count_nxt = exec_val;
        res_state_nxt = exec_e.st;
        state_nxt     = S_POST;
      end
      S_POST: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = res_count_r;
          out_state_nxt = res_state_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      wb_v_r      <= 1'b0;
      report_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      wb_v_r      <= wb_v_nxt;
      report_r    <= report_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    wb_addr_r   <= wb_addr_nxt;
    res_count_r <= res_count_nxt;
    res_state_r <= res_state_nxt;
    out_count_r <= out_count_nxt;
    out_state_r <= out_state_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_count_value = out_count_r;
  assign out_slot_state  = out_state_r;

  `STB_ASSERT_NEVER(a_no_idle_write, clk, rst_n, ram_we && ((state_r == S_IDLE) || (state_r == S_POST)), "bank write outside a command")
  `STB_ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_r > CW'(NUM_SLOTS), "sweep counter past slot count")
  `STB_ASSERT_IMPLY(a_out_from_post, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_POST, "result issued outside post state")

endmodule

// ===== sv/software_timer_bank.sv =====
// Per-slot command: its read is issued on the pop, it is updated and written back in exec,
//   then posted from the post state (which waits on out_stall) to the output register.
// A tick sweeps every slot, one per cycle through the bank memory port; a clear all zeroes it.
// A two-entry request queue takes up to two requests while the sequencer is busy.
// Reset (rst_n low, synchronous) is followed by a clearing pass that zeroes the bank;
//   in_stall stays high until the pass ends.
// Top level of the software timer bank.
module software_timer_bank #(
  parameter int NUM_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_operation,
  input  logic [3:0]  in_timer_index,
  input  logic [31:0] in_tick_amount,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_count_value,
  output logic [1:0]  out_slot_state
);

  import stb_pkg::*;

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Queue head toward the sequencer, and pop / init status coming back
  head_t    head;
  bk_stat_t stat;

  // Bank memory port: one slot entry holds state, gated and free counters
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  // Front: classify each request (drop zero ticks, per-slot commands on out-of-range
  // slots and unused codes to a no-op) and hold it until the sequencer takes it
  stb_front #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_timer_index(in_timer_index),
    .in_tick_amount(in_tick_amount),
    .stat          (stat),
    .head          (head)
  );

  // Back: run the clearing pass, tick sweeps and per-slot read-modify-write,
  // then hand the result to the output register
  stb_back #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .stat           (stat),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_rdata      (ram_rdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_count_value(out_count_value),
    .out_slot_state (out_slot_state)
  );

  // Slot bank: NUM_SLOTS entries, registered read
  stb_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_SLOTS)
  ) u_bank (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule
